@@ design/utf8dw_pkg.sv @@
// utf8 display width counter: shared types, constants and the column width table
`timescale 1ns / 1ps
`default_nettype none

package utf8dw_pkg;

  // field and count widths
  localparam int TEXT_W      = 8;
  localparam int COLUMN_W    = 16;
  localparam int COUNT_WIDTH = 16;
  localparam int PAYLOAD_W   = 12;
  localparam int HELD_W      = 2;
  localparam int CP_W        = 21;
  localparam int ADD_W       = 3;
  localparam int LEN_W       = 3;

  // total sequence lengths implied by a lead byte
  localparam logic [LEN_W-1:0] SEQ_LEN2 = 3'd2;
  localparam logic [LEN_W-1:0] SEQ_LEN3 = 3'd3;
  localparam logic [LEN_W-1:0] SEQ_LEN4 = 3'd4;

  // column counts
  localparam logic [1:0] COLS_ZERO = 2'd0;
  localparam logic [1:0] COLS_ONE  = 2'd1;
  localparam logic [1:0] COLS_TWO  = 2'd2;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic [CP_W-1:0] lo;
    logic [CP_W-1:0] hi;
    logic [1:0]      cols;
  } width_range_t;

  // decoder state carried between words
  typedef struct packed {
    logic [TEXT_W-1:0]      seq_lead;
    logic [PAYLOAD_W-1:0]   seq_payload;
    logic [HELD_W-1:0]      seq_held;
    logic [COUNT_WIDTH-1:0] column_total;
  } dec_state_t;

  localparam int WIDTH_TABLE_LEN = 20;

  localparam width_range_t WIDTH_TABLE [WIDTH_TABLE_LEN] = '{
    '{21'h00300, 21'h0036F, COLS_ZERO}, '{21'h0200B, 21'h0200F, COLS_ZERO},
    '{21'h0202A, 21'h0202E, COLS_ZERO}, '{21'h0FE00, 21'h0FE0F, COLS_ZERO},
    '{21'h0FE20, 21'h0FE2F, COLS_ZERO}, '{21'h0FEFF, 21'h0FEFF, COLS_ZERO},
    '{21'h01100, 21'h0115F, COLS_TWO},  '{21'h02E80, 21'h0303E, COLS_TWO},
    '{21'h03041, 21'h033FF, COLS_TWO},  '{21'h03400, 21'h04DBF, COLS_TWO},
    '{21'h04E00, 21'h09FFF, COLS_TWO},  '{21'h0A000, 21'h0A4CF, COLS_TWO},
    '{21'h0AC00, 21'h0D7A3, COLS_TWO},  '{21'h0F900, 21'h0FAFF, COLS_TWO},
    '{21'h0FE10, 21'h0FE19, COLS_TWO},  '{21'h0FE30, 21'h0FE6F, COLS_TWO},
    '{21'h0FF00, 21'h0FF60, COLS_TWO},  '{21'h0FFE0, 21'h0FFE6, COLS_TWO},
    '{21'h1F300, 21'h1FAFF, COLS_TWO},  '{21'h20000, 21'h3FFFD, COLS_TWO}
  };

  // display columns of one code point, first matching range wins
  function automatic logic [1:0] point_columns(input logic [CP_W-1:0] cp);
    logic [1:0] cols;
    logic       found;
    cols  = COLS_ONE;
    found = 1'b0;
    if (cp == '0) begin
      cols  = COLS_ZERO;
      found = 1'b1;
    end
    for (int i = 0; i < WIDTH_TABLE_LEN; i++) begin
      if (!found && cp >= WIDTH_TABLE[i].lo && cp <= WIDTH_TABLE[i].hi) begin
        cols  = WIDTH_TABLE[i].cols;
        found = 1'b1;
      end
    end
    return cols;
  endfunction

endpackage

`default_nettype wire

@@ design/utf8dw_if.sv @@
// utf8 display width counter: valid/ready channel interfaces for text bytes and counts
`timescale 1ns / 1ps
`default_nettype none

interface utf8dw_in_if;
  import utf8dw_pkg::*;
  logic              valid;
  logic              ready;
  logic [TEXT_W-1:0] text_byte;
  modport source (output valid, output text_byte, input ready);
  modport sink   (input valid, input text_byte, output ready);
endinterface

interface utf8dw_out_if;
  import utf8dw_pkg::*;
  logic                valid;
  logic                ready;
  logic [COLUMN_W-1:0] column_count;
  modport source (output valid, output column_count, input ready);
  modport sink   (input valid, input column_count, output ready);
endinterface

`default_nettype wire

@@ design/utf8dw_step.sv @@
// utf8 display width counter: decode of one byte against the pending sequence
`timescale 1ns / 1ps
`default_nettype none

module utf8dw_step (
  input  utf8dw_pkg::dec_state_t          cur,
  input  logic [utf8dw_pkg::TEXT_W-1:0]   text_byte,
  output utf8dw_pkg::dec_state_t          nxt,
  output logic                            emit,
  output logic [utf8dw_pkg::COLUMN_W-1:0] column_count
);
  import utf8dw_pkg::*;

  logic [LEN_W-1:0]       lead_len;
  logic [LEN_W-1:0]       held_inc;
  logic [CP_W-1:0]        cp;
  logic [5:0]             bits;
  logic                   is_cont;
  logic                   handled;
  logic [ADD_W-1:0]       add;
  logic [COUNT_WIDTH:0]   sum;
  logic [COUNT_WIDTH-1:0] sat_total;
  logic [31:0]            total_wide;
  dec_state_t             seq_nxt;

  // sequence length from the held lead byte
  always_comb begin
    if (cur.seq_lead[7:5] == 3'b110) begin
      lead_len = SEQ_LEN2;
    end else if (cur.seq_lead[7:4] == 4'b1110) begin
      lead_len = SEQ_LEN3;
    end else begin
      lead_len = SEQ_LEN4;
    end
  end

  assign bits     = text_byte[5:0];
  assign is_cont  = (text_byte[7:6] == 2'b10);
  assign held_inc = {1'b0, cur.seq_held} + LEN_W'(1);

  // code point assembly for a completing continuation
  always_comb begin
    case (lead_len)
      SEQ_LEN2: cp = {10'd0, cur.seq_lead[4:0], bits};
      SEQ_LEN3: cp = {5'd0, cur.seq_lead[3:0], cur.seq_payload[5:0], bits};
      default:  cp = {cur.seq_lead[2:0], cur.seq_payload, bits};
    endcase
  end

  // sequence tracking and column increment
  always_comb begin
    seq_nxt = cur;
    emit    = 1'b0;
    handled = 1'b0;
    add     = '0;
    if (cur.seq_held != '0) begin
      if (is_cont) begin
        handled = 1'b1;
        if (held_inc >= lead_len) begin
          add                 = {1'b0, point_columns(cp)};
          seq_nxt.seq_lead    = '0;
          seq_nxt.seq_payload = '0;
          seq_nxt.seq_held    = '0;
        end else begin
          seq_nxt.seq_payload = {cur.seq_payload[5:0], bits};
          seq_nxt.seq_held    = held_inc[HELD_W-1:0];
        end
      end else begin
        // broken sequence: one column per held byte, then a fresh byte
        add                 = {1'b0, cur.seq_held};
        seq_nxt.seq_lead    = '0;
        seq_nxt.seq_payload = '0;
        seq_nxt.seq_held    = '0;
      end
    end
    if (!handled) begin
      if (text_byte == '0) begin
        emit = 1'b1;
      end else if (text_byte inside {[8'hC0:8'hF7]}) begin
        seq_nxt.seq_lead    = text_byte;
        seq_nxt.seq_payload = '0;
        seq_nxt.seq_held    = HELD_W'(1);
      end else begin
        add = add + ADD_W'(1);
      end
    end
  end

  // saturating running total
  assign sum       = {1'b0, cur.column_total} + (COUNT_WIDTH+1)'(add);
  assign sat_total = (sum >= {1'b0, COUNT_MAX}) ? COUNT_MAX : sum[COUNT_WIDTH-1:0];
  assign total_wide   = 32'(sat_total);
  assign column_count = total_wide[COLUMN_W-1:0];

  // terminator clears everything
  always_comb begin
    nxt = seq_nxt;
    if (emit) begin
      nxt.column_total = '0;
    end else begin
      nxt.column_total = sat_total;
    end
  end

endmodule

`default_nettype wire

@@ design/utf8_display_width_counter.sv @@
// utf8 display width counter: top level with input register, decode and result register
`timescale 1ns / 1ps
`default_nettype none

// Takes one byte of a zero-terminated UTF-8 string per word and returns the
// terminal display column count of the whole string when the zero byte
// arrives, saturated at 65535; the counter then clears for the next string.
// A byte is accepted every cycle. Each accepted byte is held in the
// input register, where it is decoded against the pending sequence in a
// single pass, and a terminator's count is then loaded into the result
// register when decode proceeds. Input is held off only while a terminator
// waits behind an unread count.

module utf8_display_width_counter (
  input  logic                clk,
  input  logic                rst_n,
  utf8dw_in_if.sink           in_chan,
  utf8dw_out_if.source        out_chan
);
  import utf8dw_pkg::*;

  logic                in_v_r;
  logic [TEXT_W-1:0]   in_byte_r;
  dec_state_t          state_r;
  dec_state_t          state_nxt;
  logic                out_v_r;
  logic [COLUMN_W-1:0] out_count_r;
  logic                emit;
  logic [COLUMN_W-1:0] count;
  logic                proc_go;

  utf8dw_step u_step (
    .cur          (state_r),
    .text_byte    (in_byte_r),
    .nxt          (state_nxt),
    .emit         (emit),
    .column_count (count)
  );

  // decode proceeds unless a count has nowhere to go
  assign proc_go       = in_v_r && (!emit || !out_v_r || out_chan.ready);
  assign in_chan.ready = !in_v_r || proc_go;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_v_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      in_byte_r <= in_chan.text_byte;
    end
  end

  // decoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (proc_go) begin
      state_r <= state_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (proc_go && emit) begin
      out_v_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_go && emit) begin
      out_count_r <= count;
    end
  end

  assign out_chan.valid        = out_v_r;
  assign out_chan.column_count = out_count_r;

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
// testbench for the utf8 display width counter: byte stimulus, column count predictor, checker
`timescale 1ns / 1ps

module tb_top;
  import utf8dw_pkg::*;

  localparam int CLK_HALF      = 4;
  localparam int RESET_CYCLES  = 8;
  localparam int DRAIN_CYCLES  = 8;
  localparam int HOLD_CYCLES   = 400;
  localparam int RANDOM_BYTES  = 250;
  localparam int RANDOM_COUNTS = 15;
  localparam int TIMEOUT_NS    = 8_000_000;

  // display width spans, first match wins
  typedef struct packed {
    logic [CP_W-1:0] lo;
    logic [CP_W-1:0] hi;
    logic [1:0]      cols;
  } col_span_t;

  localparam int NUM_SPANS = 20;

  localparam col_span_t COL_SPANS [NUM_SPANS] = '{
    '{21'h00300, 21'h0036F, COLS_ZERO}, '{21'h0200B, 21'h0200F, COLS_ZERO},
    '{21'h0202A, 21'h0202E, COLS_ZERO}, '{21'h0FE00, 21'h0FE0F, COLS_ZERO},
    '{21'h0FE20, 21'h0FE2F, COLS_ZERO}, '{21'h0FEFF, 21'h0FEFF, COLS_ZERO},
    '{21'h01100, 21'h0115F, COLS_TWO},  '{21'h02E80, 21'h0303E, COLS_TWO},
    '{21'h03041, 21'h033FF, COLS_TWO},  '{21'h03400, 21'h04DBF, COLS_TWO},
    '{21'h04E00, 21'h09FFF, COLS_TWO},  '{21'h0A000, 21'h0A4CF, COLS_TWO},
    '{21'h0AC00, 21'h0D7A3, COLS_TWO},  '{21'h0F900, 21'h0FAFF, COLS_TWO},
    '{21'h0FE10, 21'h0FE19, COLS_TWO},  '{21'h0FE30, 21'h0FE6F, COLS_TWO},
    '{21'h0FF00, 21'h0FF60, COLS_TWO},  '{21'h0FFE0, 21'h0FFE6, COLS_TWO},
    '{21'h1F300, 21'h1FAFF, COLS_TWO},  '{21'h20000, 21'h3FFFD, COLS_TWO}
  };

  logic clk;
  logic rst_n;

  utf8dw_in_if  in_chan ();
  utf8dw_out_if out_chan ();

  utf8_display_width_counter u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // predicted decoder state
  logic [TEXT_W-1:0]      dec_lead;
  logic [PAYLOAD_W-1:0]   dec_bits;
  logic [HELD_W-1:0]      dec_held;
  logic [COUNT_WIDTH-1:0] dec_total;

  logic [COLUMN_W-1:0] pending_counts [$];

  int  bytes_sent;
  int  strings_sent;
  int  counts_checked;
  int  fail_count;
  bit  tx_gaps;
  bit  rx_gaps;
  bit  hold_req;

  // clock
  always begin
    clk = 1'b0;
    #CLK_HALF;
    clk = 1'b1;
    #CLK_HALF;
  end

  // columns of one code point
  function automatic logic [1:0] point_width(input logic [CP_W-1:0] cp);
    if (cp == '0) return COLS_ZERO;
    foreach (COL_SPANS[i]) begin
      if (cp >= COL_SPANS[i].lo && cp <= COL_SPANS[i].hi) return COL_SPANS[i].cols;
    end
    return COLS_ONE;
  endfunction

  // running total sticks at the top
  function automatic logic [COUNT_WIDTH-1:0] add_sat(input logic [COUNT_WIDTH-1:0] total,
                                                     input int unsigned n);
    logic [COUNT_WIDTH:0] sum;
    sum = {1'b0, total} + (COUNT_WIDTH+1)'(n);
    return (sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : sum[COUNT_WIDTH-1:0];
  endfunction

  function automatic void drop_sequence();
    dec_lead = '0;
    dec_bits = '0;
    dec_held = '0;
  endfunction

  function automatic int unsigned idle_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(12, 64);
    return $urandom_range(1, 3);
  endfunction

  // predict the effect of one accepted byte
  task automatic count_byte_columns(input logic [TEXT_W-1:0] b);
    logic [LEN_W-1:0] seq_len;
    logic [CP_W-1:0]  cp;
    if (dec_held != '0) begin
      if (b[7:6] == 2'b10) begin
        seq_len = (dec_lead[7:5] == 3'b110)  ? SEQ_LEN2 :
                  (dec_lead[7:4] == 4'b1110) ? SEQ_LEN3 : SEQ_LEN4;
        if (LEN_W'(dec_held) + LEN_W'(1) >= seq_len) begin
          case (seq_len)
            SEQ_LEN2: cp = {10'd0, dec_lead[4:0], b[5:0]};
            SEQ_LEN3: cp = {5'd0, dec_lead[3:0], dec_bits[5:0], b[5:0]};
            default:  cp = {dec_lead[2:0], dec_bits, b[5:0]};
          endcase
          dec_total = add_sat(dec_total, point_width(cp));
          drop_sequence();
        end else begin
          dec_bits = {dec_bits[5:0], b[5:0]};
          dec_held = dec_held + HELD_W'(1);
        end
        return;
      end
      // broken sequence: one column per held byte, then the byte starts afresh
      dec_total = add_sat(dec_total, dec_held);
      drop_sequence();
    end
    if (b == '0) begin
      pending_counts.push_back(dec_total);
      dec_total = '0;
    end else if (b >= 8'hC0 && b <= 8'hF7) begin
      dec_lead = b;
      dec_bits = '0;
      dec_held = HELD_W'(1);
    end else begin
      dec_total = add_sat(dec_total, 1);
    end
  endtask

  // offer one word and wait for it to be taken
  task automatic send_byte(input logic [TEXT_W-1:0] b);
    int unsigned gap;
    gap = (tx_gaps && $urandom_range(0, 99) < 30) ? idle_gap() : 0;
    if (gap != 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid     <= 1'b1;
    in_chan.text_byte <= b;
    do @(posedge clk); while (!in_chan.ready);
    count_byte_columns(b);
    bytes_sent++;
    if (b == '0) strings_sent++;
  endtask

  task automatic send_bytes(input logic [TEXT_W-1:0] seq [$]);
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  // encode a code point in len bytes, overlong where len is larger than needed
  task automatic send_point(input logic [CP_W-1:0] cp, input int unsigned len);
    case (len)
      2: begin
        send_byte({3'b110, cp[10:6]});
        send_byte({2'b10, cp[5:0]});
      end
      3: begin
        send_byte({4'b1110, cp[15:12]});
        send_byte({2'b10, cp[11:6]});
        send_byte({2'b10, cp[5:0]});
      end
      default: begin
        send_byte({5'b11110, cp[20:18]});
        send_byte({2'b10, cp[17:12]});
        send_byte({2'b10, cp[11:6]});
        send_byte({2'b10, cp[5:0]});
      end
    endcase
  endtask

  // one piece of a string: ascii, a full code point, noise or a cut-short sequence
  task automatic send_random_token();
    int unsigned pick;
    int unsigned len;
    int unsigned cont;
    logic [CP_W-1:0] cp;
    col_span_t span;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      send_byte(TEXT_W'($urandom_range(1, 127)));
    end else if (pick < 75) begin
      case ($urandom_range(0, 3))
        0: cp = CP_W'($urandom_range(0, 21'h1FFFFF));
        1: cp = CP_W'($urandom_range(0, 21'h0FFFF));
        2: begin
          span = COL_SPANS[$urandom_range(0, NUM_SPANS-1)];
          case ($urandom_range(0, 3))
            0:       cp = span.lo - 1'b1;
            1:       cp = span.lo;
            2:       cp = span.hi;
            default: cp = span.hi + 1'b1;
          endcase
        end
        default: cp = ($urandom_range(0, 1) != 0) ? '0 : CP_W'($urandom_range(1, 12'h7FF));
      endcase
      len = (cp < 21'h800) ? 2 : (cp < 21'h10000) ? 3 : 4;
      if (len < 4 && $urandom_range(0, 3) == 0) len = $urandom_range(len, 4);
      send_point(cp, len);
    end else if (pick < 90) begin
      send_byte(TEXT_W'($urandom_range(1, 255)));
    end else begin
      len = $urandom_range(2, 4);
      case (len)
        2:       send_byte(TEXT_W'($urandom_range(8'hC0, 8'hDF)));
        3:       send_byte(TEXT_W'($urandom_range(8'hE0, 8'hEF)));
        default: send_byte(TEXT_W'($urandom_range(8'hF0, 8'hF7)));
      endcase
      cont = $urandom_range(0, len - 2);
      repeat (cont) send_byte({2'b10, 6'($urandom_range(0, 63))});
      if ($urandom_range(0, 1) != 0) send_byte(TEXT_W'($urandom_range(1, 127)));
    end
  endtask

  task automatic send_random_string();
    int unsigned tokens;
    tokens = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 10);
    repeat (tokens) send_random_token();
    send_byte('0);
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_empty_string();
    logic [TEXT_W-1:0] seq [$];
    seq = '{8'h00};
    send_bytes(seq);
  endtask

  // ascii extremes, stray continuations and bytes that can never lead
  task automatic test_single_byte_columns();
    logic [TEXT_W-1:0] seq [$];
    seq = '{8'h01, 8'h7F, 8'h80, 8'hBF, 8'hF8, 8'hFF, 8'h00};
    send_bytes(seq);
  endtask

  // two, three and four byte points of zero, one and two columns
  task automatic test_code_points();
    logic [TEXT_W-1:0] seq [$];
    seq = '{8'hC3, 8'hA9, 8'hCC, 8'h80, 8'hE4, 8'hB8, 8'hAD,
            8'hF0, 8'h9F, 8'h98, 8'h80, 8'hF7, 8'hBF, 8'hBF, 8'hBF, 8'h00};
    send_bytes(seq);
  endtask

  // sequences cut by ascii and by the terminator
  task automatic test_broken_sequences();
    logic [TEXT_W-1:0] seq [$];
    seq = '{8'hE4, 8'hB8, 8'h41, 8'hF0, 8'h9F, 8'h00};
    send_bytes(seq);
  endtask

  // an overlong zero is zero width and does not end the string
  task automatic test_overlong_zero();
    logic [TEXT_W-1:0] seq [$];
    seq = '{8'hC0, 8'h80, 8'h41, 8'h00};
    send_bytes(seq);
  endtask

  // no idling on either side
  task automatic test_back_to_back();
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    repeat (10) send_random_string();
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
  endtask

  // receiver holds off while short strings keep coming, so the input stalls
  task automatic test_output_hold_off();
    tx_gaps  = 1'b0;
    hold_req = 1'b1;
    repeat (12) begin
      send_byte(TEXT_W'($urandom_range(1, 127)));
      send_byte('0);
    end
    tx_gaps = 1'b1;
  endtask

  task automatic test_random_strings();
    int start_bytes;
    int start_strings;
    start_bytes   = bytes_sent;
    start_strings = strings_sent;
    while (bytes_sent - start_bytes < RANDOM_BYTES ||
           strings_sent - start_strings < RANDOM_COUNTS) begin
      send_random_string();
    end
  endtask

  // ---------------------------------------------------------------- sequencing

  initial begin
    rst_n             <= 1'b0;
    in_chan.valid     <= 1'b0;
    in_chan.text_byte <= '0;
    tx_gaps        = 1'b1;
    rx_gaps        = 1'b1;
    hold_req       = 1'b0;
    bytes_sent     = 0;
    strings_sent   = 0;
    counts_checked = 0;
    fail_count     = 0;
    dec_total      = '0;
    drop_sequence();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_string();
    test_single_byte_columns();
    test_code_points();
    test_broken_sequences();
    test_overlong_zero();
    test_back_to_back();
    test_output_hold_off();
    test_random_strings();

    in_chan.valid <= 1'b0;
    while (pending_counts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("checked %0d column counts from %0d strings, %0d bytes in all",
             counts_checked, strings_sent, bytes_sent);
    $display("run took in bad sequences, overlong forms and a %0d cycle output stall",
             HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int unsigned stall;
    stall = 0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_chan.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (stall != 0) begin
        out_chan.ready <= 1'b0;
        stall--;
      end else begin
        out_chan.ready <= 1'b1;
        if (rx_gaps && $urandom_range(0, 99) < 20) stall = idle_gap();
      end
    end
  end

  // compare each count word against the oldest prediction
  always @(posedge clk) begin
    logic [COLUMN_W-1:0] want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_counts.size() == 0) begin
        $display("%0t: column count %0d arrived with no string pending",
                 $time, out_chan.column_count);
        fail_count++;
      end else begin
        want = pending_counts.pop_front();
        counts_checked++;
        if (out_chan.column_count !== want) begin
          $display("%0t: column count mismatch, expected %0d, actual %0d",
                   $time, want, out_chan.column_count);
          fail_count++;
        end
      end
    end
  end

  // give up if the run hangs
  initial begin
    #TIMEOUT_NS;
    $display("timeout with %0d counts outstanding", pending_counts.size());
    $display("Some tests failed");
    $finish;
  end

endmodule
